// File: rtl/ac256_pkg.sv
// Package for the AES-256 CMAC tag engine.
// Holds the S-box, round constants and round helper functions; no dependencies.
package ac256_pkg;

  localparam logic [7:0] CmacRb = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned LastRound = 14;

  localparam logic [1:0] CFG_KEY0 = 2'd0;
  localparam logic [1:0] CFG_KEY1 = 2'd1;
  localparam logic [1:0] CFG_KEY2 = 2'd2;
  localparam logic [1:0] CFG_KEY3 = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [7] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40};

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte 0 of the state sits in bits 127:120; columns are 32-bit groups.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int unsigned c, i;
    t = '0;
    for (c = 0; c < 4; c++) begin
      for (i = 0; i < 4; i++) begin
        t[127 - 8*(i + 4*c) -: 8] = SBOX[s[127 - 8*(i + 4*((c + i) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    int unsigned c;
    t = '0;
    for (c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // GF(2^128) doubling.
  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? CmacRb : 8'h00)};
  endfunction

  function automatic logic [63:0] top_bytes(input logic [63:0] x, input logic [3:0] n);
    logic [63:0] m;
    m = (n >= 4'd8) ? '1 : ~({64{1'b1}} >> {n[2:0], 3'b000});
    if (n == 4'd0) m = '0;
    return x & m;
  endfunction

  function automatic logic [63:0] pad_word(input logic [63:0] x, input logic [2:0] n);
    return top_bytes(x, {1'b0, n}) | ({56'd0, PadByte} << (6'd56 - {n, 3'b000}));
  endfunction

endpackage

// File: rtl/ac256_if.sv
// Valid/ready channel and configuration write channel interfaces.
// Depends on nothing.
interface ac256_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        message_end;
  modport source (output valid, data_word, valid_bytes, message_end, input ready);
  modport sink (input valid, data_word, valid_bytes, message_end, output ready);
endinterface

interface ac256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_half;
  logic        tag_last;
  modport source (output valid, tag_half, tag_last, input ready);
  modport sink (input valid, tag_half, tag_last, output ready);
endinterface

interface ac256_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/aes256_cmac_tag.sv
// AES-256 CMAC tag engine: one iterative round unit with on-the-fly key expansion.
// Depends on ac256_pkg and the channel interfaces in ac256_if.sv.
//
// A word that does not follow a full held block is written into the held block,
// and unless it is a last word the input is ready again on the next cycle. A
// word that follows a full held block starts one AES-256 pass (one round per
// cycle through the single round unit, key schedule stepped alongside), and the
// next word is taken only after that pass. A last word adds a subkey pass first
// when the key has been written since the subkeys were made, then a tag pass
// (building the final block, then 14 rounds); the two tag beats follow. The
// input is not ready while a pass runs or a tag waits. The result is given to
// the user via the out channel as two beats, high half first.
module aes256_cmac_tag
  import ac256_pkg::*;
(
  input logic clk,
  input logic rst_n,
  ac256_in_if.sink   in_ch,
  ac256_out_if.source out_ch,
  ac256_cfg_if.sink  cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_CHAIN, S_SUBK, S_TAG, S_OUT_HI, S_OUT_LO} state_t;
  typedef enum logic [1:0] {J_CHAIN, J_SUBK, J_TAG} job_t;

  state_t state_r, state_nxt;
  logic [63:0]  key_r [4];
  logic [127:0] chain_r, chain_nxt;
  logic [63:0]  held_r [2];
  logic [4:0]   cnt_r, cnt_nxt;
  logic [127:0] k1_r;
  logic         skr_r, skr_nxt;
  logic [127:0] aes_r, aes_nxt;
  logic [255:0] rk_r, rk_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [2:0]   rci_r, rci_nxt;
  logic [63:0]  pend_data_r, pend_data_nxt;
  logic [3:0]   pend_n_r, pend_n_nxt;
  logic         pend_end_r, pend_end_nxt;
  logic [127:0] tag_r, tag_nxt;

  logic         in_fire;
  logic [3:0]   n_in;
  logic [127:0] round_in, round_out, k2;
  logic [255:0] rk_step;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT_HI) || (state_r == S_OUT_LO);
  assign out_ch.tag_half = (state_r == S_OUT_HI) ? tag_r[127:64] : tag_r[63:0];
  assign out_ch.tag_last = (state_r == S_OUT_LO);
  assign k2 = dbl(k1_r);
  assign n_in = !in_ch.message_end ? 4'd8 :
                (in_ch.valid_bytes > 4'd8 ? 4'd8 : in_ch.valid_bytes);

  // Round unit: odd rounds use the lower half of the 256-bit window, even the upper.
  assign round_in = (rnd_r == LastRound[3:0]) ? sub_shift(aes_r) : mix_cols(sub_shift(aes_r));
  assign round_out = round_in ^ (rnd_r[0] ? rk_r[127:0] : rk_r[255:128]);

  // Every two rounds the window advances by eight words.
  always_comb begin
    logic [31:0] w [8];
    logic [31:0] t;
    for (int i = 0; i < 8; i++) w[i] = rk_r[255 - 32*i -: 32];
    t = sub_word({w[7][23:0], w[7][31:24]}) ^ {RCON[rci_r], 24'd0};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    w[4] = w[4] ^ sub_word(w[3]);
    w[5] = w[5] ^ w[4];
    w[6] = w[6] ^ w[5];
    w[7] = w[7] ^ w[6];
    rk_step = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  end

  function automatic logic [127:0] final_block(input logic [63:0] h0, input logic [63:0] h1,
                                               input logic [4:0] c, input logic [127:0] a,
                                               input logic [127:0] b);
    logic [127:0] m;
    if (c >= 5'd16) m = {h0, h1} ^ a;
    else if (c < 5'd8) m = {pad_word(h0, c[2:0]), 64'd0} ^ b;
    else m = {h0, pad_word(h1, c[2:0])} ^ b;
    return m;
  endfunction

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    cnt_nxt = cnt_r;
    skr_nxt = skr_r;
    aes_nxt = aes_r;
    rk_nxt = rk_r;
    rnd_nxt = rnd_r;
    rci_nxt = rci_r;
    pend_data_nxt = pend_data_r;
    pend_n_nxt = pend_n_r;
    pend_end_nxt = pend_end_r;
    tag_nxt = tag_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pend_data_nxt = in_ch.data_word;
          pend_n_nxt = n_in;
          pend_end_nxt = in_ch.message_end;
          rk_nxt = {key_r[0], key_r[1], key_r[2], key_r[3]};
          rnd_nxt = 4'd1;
          rci_nxt = '0;
          if (n_in != 4'd0 && cnt_r >= 5'd16) begin
            aes_nxt = chain_r ^ {held_r[0], held_r[1]} ^ {key_r[0], key_r[1]};
            state_nxt = S_CHAIN;
          end else if (in_ch.message_end && !skr_r) begin
            aes_nxt = {key_r[0], key_r[1]};
            state_nxt = S_SUBK;
          end else if (in_ch.message_end) begin
            state_nxt = S_TAG;
            rnd_nxt = 4'd0;
          end
          if (n_in != 4'd0 && cnt_r < 5'd16) begin
            cnt_nxt = (cnt_r >= 5'd8 ? 5'd8 : 5'd0) + {1'b0, n_in};
          end
        end
      end
      S_CHAIN, S_SUBK, S_TAG: begin
        if (rnd_r == 4'd0) begin
          // Tag pass start: build the final block against the current subkeys.
          aes_nxt = final_block(held_r[0], held_r[1], cnt_r, k1_r, k2) ^ chain_r
                    ^ {key_r[0], key_r[1]};
          rnd_nxt = 4'd1;
        end else begin
          aes_nxt = round_out;
          rnd_nxt = rnd_r + 4'd1;
          if (rnd_r[0]) begin
            rk_nxt = rk_step;
            rci_nxt = rci_r + 3'd1;
          end
          if (rnd_r == LastRound[3:0]) begin
            rk_nxt = {key_r[0], key_r[1], key_r[2], key_r[3]};
            rci_nxt = '0;
            rnd_nxt = 4'd0;
            if (state_r == S_CHAIN) begin
              chain_nxt = round_out;
              cnt_nxt = pend_n_r;
              state_nxt = !pend_end_r ? S_IDLE : (skr_r ? S_TAG : S_SUBK);
              if (pend_end_r && !skr_r) begin
                aes_nxt = {key_r[0], key_r[1]};
                rnd_nxt = 4'd1;
              end
            end else if (state_r == S_SUBK) begin
              skr_nxt = 1'b1;
              state_nxt = S_TAG;
            end else begin
              tag_nxt = round_out;
              chain_nxt = '0;
              cnt_nxt = '0;
              state_nxt = S_OUT_HI;
            end
          end
        end
      end
      S_OUT_HI: if (out_ch.ready) state_nxt = S_OUT_LO;
      S_OUT_LO: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_ch.valid && cfg_ch.index < 64'd4) skr_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chain_r <= '0;
      cnt_r <= '0;
      skr_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      cnt_r <= cnt_nxt;
      skr_r <= skr_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index[1:0])
          CFG_KEY0: if (cfg_ch.index[63:2] == '0) key_r[0] <= cfg_ch.data;
          CFG_KEY1: if (cfg_ch.index[63:2] == '0) key_r[1] <= cfg_ch.data;
          CFG_KEY2: if (cfg_ch.index[63:2] == '0) key_r[2] <= cfg_ch.data;
          CFG_KEY3: if (cfg_ch.index[63:2] == '0) key_r[3] <= cfg_ch.data;
          default: ;
        endcase
      end
    end
    aes_r <= aes_nxt;
    rk_r <= rk_nxt;
    rnd_r <= rnd_nxt;
    rci_r <= rci_nxt;
    pend_data_r <= pend_data_nxt;
    pend_n_r <= pend_n_nxt;
    pend_end_r <= pend_end_nxt;
    tag_r <= tag_nxt;
    // Held words: written directly while the held block is not full, after the chain pass otherwise.
    if (state_r == S_IDLE && in_fire && n_in != 4'd0 && cnt_r < 5'd16) begin
      held_r[cnt_r[3]] <= top_bytes(in_ch.data_word, n_in);
    end else if (state_r == S_CHAIN && rnd_r == LastRound[3:0]) begin
      held_r[0] <= top_bytes(pend_data_r, pend_n_r);
    end
    if (state_r == S_SUBK && rnd_r == LastRound[3:0]) k1_r <= dbl(round_out);
  end

endmodule

// File: rtl/ac256_checker.sv
// Port-level checker for the CMAC tag engine, bound to aes256_cmac_tag.
// Depends on the channel interfaces.
module ac256_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // No new beat is taken while a tag is being given.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready during tag output");

  // The high half is always followed by the low half.
  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("low half missing");

  // After the low half the block is idle again.
  a_lo_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not idle after tag");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("tag beat dropped");

endmodule

bind aes256_cmac_tag ac256_checker u_ac256_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.tag_last)
);
